[hw/rtl/sstf_pkg.sv]
// Shared types and constants of the shortest-seek-first request scheduler.
package sstf_pkg;

  // Defaults of the top-level parameters.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int REQUESTERS_DEF  = 16;
  localparam int TRACK_BITS_DEF  = 10;

  // Fixed field widths.
  localparam int ID_W     = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUEUE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_COUNT  = 1'b1;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] MAX_QUEUE_RST = 5'd16;
  localparam logic [CFG_W-1:0] REQ_COUNT_RST = 5'd0;

  // Request types.
  localparam logic REQ_TRACK  = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_ACCEPTED     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REF_PENDING  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REF_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FIN_PENDING  = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SERVE,
    S_COMPACT
  } state_e;

endpackage

[hw/rtl/sstf_dist_unit.sv]
// Shared seek distance unit: absolute track distance and nearest-candidate compare.
module sstf_dist_unit #(
  parameter int TRACK_BITS = sstf_pkg::TRACK_BITS_DEF
) (
  input  logic [TRACK_BITS-1:0] cand_track_i,
  input  logic [TRACK_BITS-1:0] head_track_i,
  input  logic [TRACK_BITS-1:0] best_dist_i,
  input  logic                  first_i,
  output logic [TRACK_BITS-1:0] dist_o,
  output logic                  take_o
);

  // Absolute distance from the head to the candidate track.
  assign dist_o = (cand_track_i > head_track_i) ? (cand_track_i - head_track_i)
                                                : (head_track_i - cand_track_i);

  // The first candidate always wins; later ones only when strictly closer.
  assign take_o = first_i || (dist_o < best_dist_i);

endmodule

[hw/rtl/sstf_entry_table.sv]
// Arrival-ordered table of pending requests: one write port, one registered read port.
module sstf_entry_table #(
  parameter int QUEUE_DEPTH = sstf_pkg::QUEUE_DEPTH_DEF,
  parameter int TRACK_BITS  = sstf_pkg::TRACK_BITS_DEF,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [sstf_pkg::ID_W-1:0]   wowner_i,
  input  logic [TRACK_BITS-1:0]       wtrack_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [sstf_pkg::ID_W-1:0]   rowner_o,
  output logic [TRACK_BITS-1:0]       rtrack_o
);

  logic [sstf_pkg::ID_W-1:0] owner_mem [QUEUE_DEPTH];
  logic [TRACK_BITS-1:0]     track_mem [QUEUE_DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      owner_mem[waddr_i] <= wowner_i;
      track_mem[waddr_i] <= wtrack_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rowner_o <= owner_mem[raddr_i];
    rtrack_o <= track_mem[raddr_i];
  end

endmodule

[hw/rtl/sstf_disk_request_scheduler.sv]
// Top level of the shortest-seek-first disk request scheduler and its sequencer.
//
// Usage: an event (req_type_i, requester_id_i, track_i) is taken at a rising
// edge with start_i high and busy_o low. A track request joins the pending
// table unless its requester already has one pending or the table is full to
// min(max_queue, live requesters, QUEUE_DEPTH). A finish retires one live
// requester unless that requester still has a request pending. After an
// accepted event, when the table is non-empty and full to that threshold, the
// entry nearest the head track is served (oldest wins ties) and the head
// moves there. Each event gives exactly one result, shown for one cycle with
// done_o high. busy_o is high from the accept until the result strobe. The
// table has a single read port, read once per entry by the nearest-track
// scan and again, for the entries behind the served one, by the compaction.
// The results cannot be held off; the next event may be started in the cycle
// of the strobe. Reset empties the table, puts the head at track 0, clears
// the finish count and loads max_queue = 16 and requester_count = 0.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once.
module sstf_disk_request_scheduler #(
  parameter int QUEUE_DEPTH = sstf_pkg::QUEUE_DEPTH_DEF,
  parameter int REQUESTERS  = sstf_pkg::REQUESTERS_DEF,
  parameter int TRACK_BITS  = sstf_pkg::TRACK_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Event channel.
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               req_type_i,
  input  logic [sstf_pkg::ID_W-1:0]          requester_id_i,
  input  logic [TRACK_BITS-1:0]              track_i,
  // Result channel.
  output logic                               done_o,
  output logic [sstf_pkg::STATUS_W-1:0]      status_o,
  output logic                               served_valid_o,
  output logic [sstf_pkg::ID_W-1:0]          served_requester_o,
  output logic [TRACK_BITS-1:0]              served_track_o,
  // Configuration port.
  input  logic                               cfg_we_i,
  input  logic [sstf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sstf_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int CfgW  = sstf_pkg::CFG_W;
  localparam int IdW   = sstf_pkg::ID_W;
  localparam int StW   = sstf_pkg::STATUS_W;
  localparam int CmpW  = (CntW > CfgW) ? CntW : CfgW;
  localparam int ReqW  = $clog2(REQUESTERS + 1);
  localparam int RcW   = (ReqW > CfgW) ? ReqW : CfgW;

  sstf_pkg::state_e state_q, state_d;

  // Configuration and architectural state.
  logic [CfgW-1:0]       maxq_q, rc_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [TRACK_BITS-1:0] head_q, head_d;
  logic [CfgW-1:0]       fin_q, fin_d;

  // Latched event.
  logic                  ev_type_q, ev_type_d;
  logic [IdW-1:0]        ev_id_q, ev_id_d;
  logic [TRACK_BITS-1:0] ev_trk_q, ev_trk_d;

  // Sequencer working registers.
  logic [CntW-1:0]       idx_q, idx_d;
  logic                  rvalid_q, rvalid_d;
  logic [AW-1:0]         ridx_q, ridx_d;
  logic                  pend_q, pend_d;
  logic                  have_best_q, have_best_d;
  logic [AW-1:0]         best_idx_q, best_idx_d;
  logic [TRACK_BITS-1:0] best_dist_q, best_dist_d;
  logic [IdW-1:0]        best_owner_q, best_owner_d;
  logic [TRACK_BITS-1:0] best_track_q, best_track_d;

  // Result registers.
  logic                  done_q, done_d;
  logic [StW-1:0]        status_q, status_d;
  logic                  sv_q, sv_d;
  logic [IdW-1:0]        sreq_q, sreq_d;
  logic [TRACK_BITS-1:0] strk_q, strk_d;

  // Table ports.
  logic                  tbl_we;
  logic [AW-1:0]         tbl_waddr;
  logic [IdW-1:0]        tbl_wowner;
  logic [TRACK_BITS-1:0] tbl_wtrack;
  logic [IdW-1:0]        rd_owner;
  logic [TRACK_BITS-1:0] rd_track;

  // Distance unit ports.
  logic [TRACK_BITS-1:0] cand_track;
  logic [TRACK_BITS-1:0] seek_dist;
  logic                  take;

  // Threshold path.
  logic [RcW-1:0]        rc_ext, rc_lim;
  logic [CfgW-1:0]       rc_clamped, live, thr_small;
  logic [CmpW-1:0]       thr, cnt_ext;
  logic                  table_full, serve;

  sstf_entry_table #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TRACK_BITS  (TRACK_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (tbl_we),
    .waddr_i  (tbl_waddr),
    .wowner_i (tbl_wowner),
    .wtrack_i (tbl_wtrack),
    .raddr_i  (idx_q[AW-1:0]),
    .rowner_o (rd_owner),
    .rtrack_o (rd_track)
  );

  sstf_dist_unit #(
    .TRACK_BITS (TRACK_BITS)
  ) u_dist (
    .cand_track_i (cand_track),
    .head_track_i (head_q),
    .best_dist_i  (best_dist_q),
    .first_i      (!have_best_q),
    .dist_o       (seek_dist),
    .take_o       (take)
  );

  // The scan feeds table entries to the distance unit; the decide step feeds the new request.
  assign cand_track = (state_q == sstf_pkg::S_DECIDE) ? ev_trk_q : rd_track;

  // Live requesters and fill threshold.
  assign rc_ext     = RcW'(rc_q);
  assign rc_lim     = RcW'(REQUESTERS);
  assign rc_clamped = (rc_ext > rc_lim) ? CfgW'(rc_lim) : rc_q;
  assign live       = (rc_clamped > fin_q) ? (rc_clamped - fin_q) : '0;
  assign thr_small  = (maxq_q < live) ? maxq_q : live;
  assign thr        = (CmpW'(thr_small) > CmpW'(QUEUE_DEPTH)) ? CmpW'(QUEUE_DEPTH)
                                                              : CmpW'(thr_small);
  assign cnt_ext    = CmpW'(cnt_q);
  assign table_full = (cnt_ext >= thr) || (cnt_q >= CntW'(QUEUE_DEPTH));

  // Serve decision, taken with the count and finish count updated by the event.
  assign serve = (status_q == sstf_pkg::STATUS_ACCEPTED) && (cnt_q != '0) && (cnt_ext >= thr);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sstf_pkg::S_IDLE: begin
        if (start_i) state_d = sstf_pkg::S_SCAN;
      end
      sstf_pkg::S_SCAN: begin
        if (idx_q >= cnt_q) state_d = sstf_pkg::S_DECIDE;
      end
      sstf_pkg::S_DECIDE: begin
        state_d = sstf_pkg::S_SERVE;
      end
      sstf_pkg::S_SERVE: begin
        state_d = serve ? sstf_pkg::S_COMPACT : sstf_pkg::S_IDLE;
      end
      sstf_pkg::S_COMPACT: begin
        if (idx_q > cnt_q) state_d = sstf_pkg::S_IDLE;
      end
      default: state_d = sstf_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    cnt_d        = cnt_q;
    head_d       = head_q;
    fin_d        = fin_q;
    ev_type_d    = ev_type_q;
    ev_id_d      = ev_id_q;
    ev_trk_d     = ev_trk_q;
    idx_d        = idx_q;
    rvalid_d     = 1'b0;
    ridx_d       = ridx_q;
    pend_d       = pend_q;
    have_best_d  = have_best_q;
    best_idx_d   = best_idx_q;
    best_dist_d  = best_dist_q;
    best_owner_d = best_owner_q;
    best_track_d = best_track_q;
    done_d       = 1'b0;
    status_d     = status_q;
    sv_d         = sv_q;
    sreq_d       = sreq_q;
    strk_d       = strk_q;
    tbl_we       = 1'b0;
    tbl_waddr    = ridx_q;
    tbl_wowner   = rd_owner;
    tbl_wtrack   = rd_track;

    unique case (state_q)
      // Latch the event and start the scan at the oldest entry.
      sstf_pkg::S_IDLE: begin
        if (start_i) begin
          ev_type_d   = req_type_i;
          ev_id_d     = requester_id_i;
          ev_trk_d    = track_i;
          idx_d       = '0;
          pend_d      = 1'b0;
          have_best_d = 1'b0;
        end
      end

      // One entry per cycle: owner match and nearest-track tracking.
      sstf_pkg::S_SCAN: begin
        if (rvalid_q) begin
          if (rd_owner == ev_id_q) pend_d = 1'b1;
          if (take) begin
            have_best_d  = 1'b1;
            best_idx_d   = ridx_q;
            best_dist_d  = seek_dist;
            best_owner_d = rd_owner;
            best_track_d = rd_track;
          end
        end
        if (idx_q < cnt_q) begin
          idx_d    = idx_q + 1'b1;
          rvalid_d = 1'b1;
          ridx_d   = idx_q[AW-1:0];
        end
      end

      // Settle the status, append an accepted request, count a finish.
      sstf_pkg::S_DECIDE: begin
        status_d = sstf_pkg::STATUS_ACCEPTED;
        if (ev_type_q == sstf_pkg::REQ_TRACK) begin
          if (pend_q) begin
            status_d = sstf_pkg::STATUS_REF_PENDING;
          end else if (table_full) begin
            status_d = sstf_pkg::STATUS_REF_FULL;
          end else begin
            tbl_we     = 1'b1;
            tbl_waddr  = cnt_q[AW-1:0];
            tbl_wowner = ev_id_q;
            tbl_wtrack = ev_trk_q;
            cnt_d      = cnt_q + 1'b1;
            if (take) begin
              have_best_d  = 1'b1;
              best_idx_d   = cnt_q[AW-1:0];
              best_dist_d  = seek_dist;
              best_owner_d = ev_id_q;
              best_track_d = ev_trk_q;
            end
          end
        end else begin
          if (pend_q) begin
            status_d = sstf_pkg::STATUS_FIN_PENDING;
          end else if (live != '0) begin
            fin_d = fin_q + 1'b1;
          end
        end
      end

      // Serve the nearest entry or report the event right away.
      sstf_pkg::S_SERVE: begin
        if (serve) begin
          sv_d   = 1'b1;
          sreq_d = best_owner_q;
          strk_d = best_track_q;
          head_d = best_track_q;
          cnt_d  = cnt_q - 1'b1;
          idx_d  = CntW'(best_idx_q) + 1'b1;
        end else begin
          sv_d   = 1'b0;
          sreq_d = '0;
          strk_d = '0;
          done_d = 1'b1;
        end
      end

      // Close the gap: each entry behind the served one moves down by one.
      sstf_pkg::S_COMPACT: begin
        if (rvalid_q) tbl_we = 1'b1;
        if (idx_q <= cnt_q) begin
          idx_d    = idx_q + 1'b1;
          rvalid_d = 1'b1;
          ridx_d   = idx_q[AW-1:0] - 1'b1;
        end else begin
          done_d = 1'b1;
        end
      end

      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxq_q <= sstf_pkg::MAX_QUEUE_RST;
      rc_q   <= sstf_pkg::REQ_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sstf_pkg::CFG_MAX_QUEUE: maxq_q <= cfg_data_i;
        sstf_pkg::CFG_REQ_COUNT: rc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sstf_pkg::S_IDLE;
      cnt_q    <= '0;
      head_q   <= '0;
      fin_q    <= '0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      head_q   <= head_d;
      fin_q    <= fin_d;
      rvalid_q <= rvalid_d;
      done_q   <= done_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    ev_type_q    <= ev_type_d;
    ev_id_q      <= ev_id_d;
    ev_trk_q     <= ev_trk_d;
    idx_q        <= idx_d;
    ridx_q       <= ridx_d;
    pend_q       <= pend_d;
    have_best_q  <= have_best_d;
    best_idx_q   <= best_idx_d;
    best_dist_q  <= best_dist_d;
    best_owner_q <= best_owner_d;
    best_track_q <= best_track_d;
    status_q     <= status_d;
    sv_q         <= sv_d;
    sreq_q       <= sreq_d;
    strk_q       <= strk_d;
  end

  assign busy_o             = (state_q != sstf_pkg::S_IDLE);
  assign done_o             = done_q;
  assign status_o           = status_q;
  assign served_valid_o     = sv_q;
  assign served_requester_o = sreq_q;
  assign served_track_o     = strk_q;

endmodule

[hw/rtl/sstf_checker.sv]
// Port-level checks of the scheduler, attached to the top level by bind.
module sstf_checker #(
  parameter int TRACK_BITS = sstf_pkg::TRACK_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input logic [sstf_pkg::STATUS_W-1:0]  status_o,
  input logic                           served_valid_o,
  input logic [sstf_pkg::ID_W-1:0]      served_requester_o,
  input logic [TRACK_BITS-1:0]          served_track_o
);

  // A result is only reported once the block has gone idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An accepted event always keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start_i && !busy_o) |=> busy_o)
    else $error("accepted event did not start the sequencer");

  // A refused event never serves a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != sstf_pkg::STATUS_ACCEPTED) |-> !served_valid_o)
    else $error("refused event served a request");

  // Without a served request the served fields read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !served_valid_o) |-> (served_requester_o == '0 && served_track_o == '0))
    else $error("served fields not cleared");

endmodule

bind sstf_disk_request_scheduler sstf_checker #(
  .TRACK_BITS (TRACK_BITS)
) u_sstf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start_i            (start_i),
  .busy_o             (busy_o),
  .done_o             (done_o),
  .status_o           (status_o),
  .served_valid_o     (served_valid_o),
  .served_requester_o (served_requester_o),
  .served_track_o     (served_track_o)
);
